// File: rtl/core/smpq_pkg.sv
`default_nettype none

package smpq_pkg;

  localparam int ValueW = 32;
  localparam int PrioW  = 16;

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } smpq_entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic        enq;
    logic        deq;
    smpq_entry_t entry;
  } smpq_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/smpq_cell.sv
`default_nettype none

module smpq_cell (
  input  wire logic                 clk_i,
  input  wire smpq_pkg::smpq_ctrl_t ctrl_i,
  input  wire logic                 occupied_i,
  input  wire logic                 prev_after_i,
  input  wire smpq_pkg::smpq_entry_t prev_entry_i,
  input  wire smpq_pkg::smpq_entry_t next_entry_i,
  output logic                      after_o,
  output smpq_pkg::smpq_entry_t     entry_o
);
  import smpq_pkg::*;

  smpq_entry_t entry_q, entry_d;

  // stored entry stays ahead of the new one on ties (arrival order kept)
  assign after_o = occupied_i && (entry_q.prio <= ctrl_i.entry.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (!after_o) begin
        entry_d = prev_after_i ? ctrl_i.entry : prev_entry_i;
      end
    end else if (ctrl_i.deq) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// File: rtl/core/stable_min_priority_queue.sv
// A result is registered in the cycle after its transaction is accepted.
// One transaction per cycle while in_ready_o is high; each cell compares its priority with
// the incoming one in parallel, so enqueue and dequeue both update every cell at once.
// in_ready_o drops only while a result waits and out_ready_i is low.
// Reset (rst_ni, async, active low) empties the queue and clears out_valid_o;
// cell contents are not cleared and are never read before being written.
`default_nettype none

module stable_min_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             command_i,
  input  wire logic signed [smpq_pkg::ValueW-1:0] item_value_i,
  input  wire logic signed [smpq_pkg::PrioW-1:0]  item_priority_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [smpq_pkg::ValueW-1:0]    out_value_o,
  output logic        [1:0]                     status_o,
  output logic        [4:0]                     entry_count_o
);
  import smpq_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(CAPACITY);

  // occupancy count; cell i holds a live entry when i < count_q
  logic [CntW-1:0] count_q, count_d;

  // output register
  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_value_q, out_value_d;
  logic [1:0]               status_q, status_d;
  logic [31:0]              count_ext;

  logic accept;
  logic full, empty;
  smpq_ctrl_t ctrl;

  // cell chain links
  smpq_entry_t entries [CAPACITY];
  logic [CAPACITY-1:0] after;
  logic [CAPACITY-1:0] occupied;

  // output stage frees up in the same cycle it is drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = (count_q == CntMax);
  assign empty = (count_q == '0);

  assign ctrl.enq         = accept && (command_i == CMD_ENQ) && !full;
  assign ctrl.deq         = accept && (command_i == CMD_DEQ) && !empty;
  assign ctrl.entry.value = item_value_i;
  assign ctrl.entry.prio  = item_priority_i;

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic        prev_after;
      smpq_entry_t prev_entry;
      smpq_entry_t next_entry;

      assign occupied[i] = (count_q > CntW'(i));

      if (i == 0) begin : g_head
        // head cell: nothing ahead, so a non-trailing head takes the new entry
        assign prev_after = 1'b0;
        assign prev_entry = ctrl.entry;
      end else begin : g_body
        assign prev_after = after[i-1];
        assign prev_entry = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        // tail holds on dequeue; its content is beyond the count afterwards
        assign next_entry = entries[i];
      end else begin : g_mid
        assign next_entry = entries[i+1];
      end

      smpq_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .occupied_i   (occupied[i]),
        .prev_after_i (prev_after),
        .prev_entry_i (prev_entry),
        .next_entry_i (next_entry),
        .after_o      (after[i]),
        .entry_o      (entries[i])
      );
    end
  endgenerate

  // next count and result of the accepted transaction
  always_comb begin
    count_d     = count_q;
    out_value_d = '0;
    status_d    = ST_ENQUEUED;
    if (command_i == CMD_ENQ) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d    = ST_DEQUEUED;
        out_value_d = entries[0].value;
        count_d     = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q <= out_value_d;
      status_q    <= status_d;
    end
  end

  // count_q already reflects the last accepted transaction
  assign count_ext     = 32'(count_q);
  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign status_o      = status_q;
  assign entry_count_o = count_ext[4:0];

endmodule

`default_nettype wire
